@@ rtl/core/lage_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lage_pkg: shared definitions for the life generation engine
// Field geometry, memory layout, stream widths, action codes, FSM states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lage_pkg;

    localparam int FIELD_W = 64;
    localparam int FIELD_H = 64;

    localparam int COL_W     = $clog2(FIELD_W);
    localparam int ROW_W     = $clog2(FIELD_H);
    localparam int MEM_AW    = ROW_W + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // Rows H-2 .. H+1 (mod H) are read, so every row sees two rows each side.
    localparam int SWEEP_READS = FIELD_H + 4;
    localparam int K_W         = $clog2(SWEEP_READS + 1);

    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(FIELD_H - 1);
    localparam logic [ROW_W-1:0] ROW_START = ROW_W'(FIELD_H - 2);
    localparam logic [K_W-1:0]   K_LAST    = K_W'(SWEEP_READS);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int GEN_W       = 32;

    localparam logic [1:0] ACT_SET     = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic sweep_start;
        logic sweep_run;
        logic commit;
        logic rd_item;
        logic wr_set;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic item_is_set;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/life_automaton_generation_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_generation_engine: B3/S23 life engine on a wrapped field
// Set, read and advance items on a row-major cell field held in memory.
// ----------------------------------------------------------------------------
// Set and read: the item goes through ST_ROW_RD, ST_ROW_WAIT and ST_RESP to
// the output register; the next item is taken in ST_IDLE. An advance item
// first sweeps, one field-memory row read per cycle over FIELD_H + 4 rows.
// One item in work at a time; a result may wait in the output register.
// Reset clears the field at once through per-row valid bits and sets the
// generation to one; no clearing pass is needed.
module life_automaton_generation_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [5:0] cell_x, [11:6] cell_y, [15:12] zero
    input  wire logic [lage_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] cell_alive, [32:1] generation, [39:33] zero
    output logic [lage_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    lage_pkg::cmd_t    cmd;
    lage_pkg::status_t status;

    lage_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    lage_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
`default_nettype wire

@@ rtl/core/lage_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lage_ctrl: sequencer of the life generation engine
// Takes one item at a time, steps the datapath through the generation sweep
// or the row access, and owns the output valid flag.
// ----------------------------------------------------------------------------
module lage_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire lage_pkg::status_t status,
    output lage_pkg::cmd_t        cmd
);

    lage_pkg::state_t state_reg;
    lage_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lage_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            lage_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    unique case (s_axis_tuser)
                        lage_pkg::ACT_ADVANCE:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = lage_pkg::ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = lage_pkg::ST_ROW_RD;
                        end
                    endcase
                end
            end
            lage_pkg::ST_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.commit = 1'b1;
                    state_next = lage_pkg::ST_ROW_RD;
                end
            end
            lage_pkg::ST_ROW_RD:
            begin
                cmd.rd_item = 1'b1;
                state_next  = lage_pkg::ST_ROW_WAIT;
            end
            lage_pkg::ST_ROW_WAIT:
            begin
                cmd.wr_set = status.item_is_set;
                state_next = lage_pkg::ST_RESP;
            end
            lage_pkg::ST_RESP:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lage_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lage_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/core/lage_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lage_datapath: field memory and generation datapath
// Two banks of row-wide field memory with per-row valid bits, a five-row
// window that feeds one row of rule lanes, the generation counter and the
// output register.
// ----------------------------------------------------------------------------
module lage_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [lage_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic [1:0]                           s_axis_tuser,
    output logic [lage_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    input  wire lage_pkg::cmd_t                       cmd,
    output lage_pkg::status_t                         status
);

    localparam int W = lage_pkg::FIELD_W;

    // Field storage: address is {bank, row}.
    logic [W-1:0] field_mem [lage_pkg::MEM_DEPTH];

    logic [lage_pkg::MEM_DEPTH-1:0] row_valid_reg;
    logic [W-1:0]                   rd_data_reg;
    logic                           rd_valid_reg;
    logic                           bank_reg;
    logic [lage_pkg::GEN_W-1:0]     gen_reg;

    logic [1:0] item_action_reg;
    logic [5:0] item_x_reg;
    logic [5:0] item_y_reg;

    logic [lage_pkg::K_W-1:0]   k_reg;
    logic [lage_pkg::ROW_W-1:0] rd_row_reg;
    logic                       rd_pend_reg;
    logic [2:0]                 fill_reg;
    logic                       wr_pend_reg;
    logic [lage_pkg::ROW_W-1:0] wr_row_reg;
    logic [W-1:0]               win_reg [5];

    logic                       out_alive_reg;
    logic [lage_pkg::GEN_W-1:0] out_gen_reg;

    logic                        in_field;
    logic [lage_pkg::ROW_W-1:0]  item_row;
    logic [lage_pkg::COL_W-1:0]  item_col;
    logic [W-1:0]                row_in;
    logic                        sweep_issue;
    logic                        rd_en;
    logic [lage_pkg::MEM_AW-1:0] rd_addr;
    logic                        wr_en;
    logic [lage_pkg::MEM_AW-1:0] wr_addr;
    logic [W-1:0]                wr_data;
    logic [3*W+1:0]              ext;
    logic [3:0]                  nb_cnt [W];
    logic [W-1:0]                next_row;
    logic                        alive;

    assign in_field = (32'(item_x_reg) < lage_pkg::FIELD_W) &&
                      (32'(item_y_reg) < lage_pkg::FIELD_H);
    assign item_row = lage_pkg::ROW_W'(item_y_reg);
    assign item_col = lage_pkg::COL_W'(item_x_reg);
    assign row_in   = rd_valid_reg ? rd_data_reg : '0;

    assign sweep_issue = cmd.sweep_run && (k_reg != lage_pkg::K_LAST);

    // Memory port selection.
    always_comb
    begin
        rd_en   = sweep_issue || cmd.rd_item;
        rd_addr = sweep_issue ? {bank_reg, rd_row_reg} : {bank_reg, item_row};
        if (wr_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = {~bank_reg, wr_row_reg};
            wr_data = next_row;
        end
        else
        begin
            wr_en   = cmd.wr_set && in_field;
            wr_addr = {bank_reg, item_row};
            wr_data = row_in | (W'(1) << item_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            field_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= field_mem[rd_addr];
        end
    end

    // A row never written since reset reads as all dead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // The window holds rows y-2 .. y+2; the ring of cells continues from the
    // last cell of one row into the first cell of the next.
    assign ext = {win_reg[4][0], win_reg[3], win_reg[2], win_reg[1], win_reg[0][W-1]};

    always_comb
    begin
        for (int x = 0; x < W; x++)
        begin
            nb_cnt[x] = 4'(ext[x])         + 4'(ext[x + 1])       + 4'(ext[x + 2]) +
                        4'(ext[W + x])     + 4'(ext[W + x + 2])   +
                        4'(ext[2*W + x])   + 4'(ext[2*W + x + 1]) + 4'(ext[2*W + x + 2]);
            next_row[x] = (nb_cnt[x] == 4'd3) || (win_reg[2][x] && (nb_cnt[x] == 4'd2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            gen_reg     <= lage_pkg::GEN_W'(1);
            k_reg       <= '0;
            rd_row_reg  <= '0;
            rd_pend_reg <= 1'b0;
            fill_reg    <= '0;
            wr_pend_reg <= 1'b0;
            wr_row_reg  <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                bank_reg <= ~bank_reg;
                gen_reg  <= gen_reg + 1'b1;
            end
            if (cmd.sweep_start)
            begin
                k_reg       <= '0;
                rd_row_reg  <= lage_pkg::ROW_START;
                rd_pend_reg <= 1'b0;
                fill_reg    <= '0;
                wr_pend_reg <= 1'b0;
                wr_row_reg  <= '0;
            end
            else
            begin
                rd_pend_reg <= sweep_issue;
                if (sweep_issue)
                begin
                    k_reg      <= k_reg + 1'b1;
                    rd_row_reg <= (rd_row_reg == lage_pkg::ROW_LAST) ? '0 : rd_row_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    fill_reg    <= (fill_reg == 3'd5) ? fill_reg : fill_reg + 1'b1;
                    wr_pend_reg <= (fill_reg >= 3'd4);
                end
                else
                begin
                    wr_pend_reg <= 1'b0;
                end
                if (wr_pend_reg)
                begin
                    wr_row_reg <= (wr_row_reg == lage_pkg::ROW_LAST) ? '0 : wr_row_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            for (int s = 0; s < 4; s++)
            begin
                win_reg[s] <= win_reg[s + 1];
            end
            win_reg[4] <= row_in;
        end
        if (cmd.capture)
        begin
            item_action_reg <= s_axis_tuser;
            item_x_reg      <= s_axis_tdata[5:0];
            item_y_reg      <= s_axis_tdata[11:6];
        end
        if (cmd.load_out)
        begin
            out_alive_reg <= alive;
            out_gen_reg   <= gen_reg;
        end
    end

    always_comb
    begin
        case (item_action_reg)
            lage_pkg::ACT_SET: alive = in_field;
            default:           alive = in_field && row_in[item_col];
        endcase
    end

    assign status.sweep_last  = wr_pend_reg && (wr_row_reg == lage_pkg::ROW_LAST);
    assign status.item_is_set = (item_action_reg == lage_pkg::ACT_SET);

    assign m_axis_tdata = {7'd0, out_gen_reg, out_alive_reg};

endmodule
`default_nettype wire

@@ rtl/core/lage_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lage_checker: port-level checks for the life generation engine
// Watches the stream ports for ordering, occupancy and generation progress.
// ----------------------------------------------------------------------------
module lage_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [lage_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic [1:0]                        s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [lage_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic                       in_acc;
    logic                       out_acc;
    logic [1:0]                 open_reg;
    logic [lage_pkg::GEN_W-1:0] last_gen_reg;
    logic [lage_pkg::GEN_W-1:0] out_gen;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign out_gen = m_axis_tdata[32:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= '0;
            last_gen_reg <= lage_pkg::GEN_W'(1);
        end
        else
        begin
            open_reg <= open_reg + 2'(in_acc) - 2'(out_acc);
            if (out_acc)
            begin
                last_gen_reg <= out_gen;
            end
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("item taken while another is in work");

    // At most one item in work plus one result waiting.
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg <= 2'd2) && (!m_axis_tvalid || (open_reg != 2'd0)))
        else $error("result count out of step with items");

    // Each result advances the generation by at most one.
    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (out_gen == last_gen_reg) || (out_gen == last_gen_reg + 1'b1))
        else $error("generation jumped");

endmodule

bind life_automaton_generation_engine lage_checker u_lage_checker (.*);
`default_nettype wire

@@ dv/tb_life_automaton_generation_engine.sv @@
// ----------------------------------------------------------------------------
// tb_life_automaton_generation_engine: self-checking bench for the life engine
// Drives set, read and advance items into the stream input. A scoreboard keeps
// its own copy of the cell field and generation count, predicts each result,
// and compares it field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_life_automaton_generation_engine;

    localparam int FIELD_W = lage_pkg::FIELD_W;
    localparam int FIELD_H = lage_pkg::FIELD_H;
    localparam int CELLS   = FIELD_W * FIELD_H;

    // The spare action code behaves as a read.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int ITEM_TARGET = 140;

    typedef struct {
        bit        alive;
        bit [31:0] generation;
    } cell_report_t;

    class life_scoreboard;
        bit           field [CELLS];
        bit [31:0]    gen_count;
        cell_report_t report_q[$];
        int           errors;

        function new();
            foreach (field[i])
                field[i] = 1'b0;
            gen_count = 32'd1;
            errors    = 0;
        endfunction

        function int live_at(int i);
            return field[(i + CELLS) % CELLS];
        endfunction

        // Linear neighbors wrap over the whole field, so a column edge reaches
        // into the adjacent row and the first and last cells touch.
        function void step_generation();
            bit nxt [CELLS];
            int above;
            int below;
            int n;
            for (int i = 0; i < CELLS; i++)
            begin
                above = (i + CELLS - FIELD_W) % CELLS;
                below = (i + FIELD_W) % CELLS;
                n = live_at(i - 1) + live_at(i + 1) +
                    live_at(above - 1) + live_at(above) + live_at(above + 1) +
                    live_at(below - 1) + live_at(below) + live_at(below + 1);
                if (field[i])
                    nxt[i] = (n == 2 || n == 3);
                else
                    nxt[i] = (n == 3);
            end
            field     = nxt;
            gen_count = gen_count + 32'd1;
        endfunction

        function void note_item(logic [1:0] action, logic [5:0] x, logic [5:0] y);
            cell_report_t rep;
            int           idx;
            idx = int'(y) * FIELD_W + int'(x);
            if (action == lage_pkg::ACT_SET)
                field[idx] = 1'b1;
            else if (action == lage_pkg::ACT_ADVANCE)
                step_generation();
            rep.alive      = field[idx];
            rep.generation = gen_count;
            report_q.push_back(rep);
        endfunction

        function void check_result(logic [lage_pkg::OUT_TDATA_W-1:0] data);
            cell_report_t want;
            if (report_q.size() == 0)
            begin
                $error("unexpected result: cell_alive %0d generation %0d",
                       data[0], data[32:1]);
                errors++;
                return;
            end
            want = report_q.pop_front();
            if (data[0] !== want.alive)
            begin
                $error("cell_alive: expected %0d, actual %0d", want.alive, data[0]);
                errors++;
            end
            if (data[32:1] !== want.generation)
            begin
                $error("generation: expected %0d, actual %0d", want.generation,
                       data[32:1]);
                errors++;
            end
        endfunction

        function int pending();
            return report_q.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [lage_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic [1:0]                          s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [lage_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    life_scoreboard sb = new();
    int sender_idle_pct   = 38;
    int receiver_idle_pct = 70;
    int items_sent        = 0;

    life_automaton_generation_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic send_item(logic [1:0] action, logic [5:0] x, logic [5:0] y);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, y, x};
        s_axis_tuser  <= action;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(action, x, y);
        items_sent++;
    endtask

    // A small pattern near a random origin, then a few generations read back
    // around it, so that advances see live neighborhoods.
    task automatic run_pattern_burst();
        logic [5:0] ox;
        logic [5:0] oy;
        int         n_set;
        int         n_adv;
        ox    = 6'($urandom_range(63));
        oy    = 6'($urandom_range(63));
        n_set = $urandom_range(3, 8);
        n_adv = $urandom_range(1, 3);
        repeat (n_set)
            send_item(lage_pkg::ACT_SET, 6'(ox + $urandom_range(3)),
                      6'(oy + $urandom_range(3)));
        repeat (n_adv)
        begin
            send_item(lage_pkg::ACT_ADVANCE, 6'(ox + $urandom_range(5) + 63),
                      6'(oy + $urandom_range(5) + 63));
            if ($urandom_range(1))
                send_item(($urandom_range(1) != 0) ? lage_pkg::ACT_READ : ACT_SPARE,
                          6'(ox + $urandom_range(5) + 63),
                          6'(oy + $urandom_range(5) + 63));
        end
    endtask

    task automatic run_random_until(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 75)
                run_pattern_burst();
            else
                send_item(2'($urandom_range(3)), 6'($urandom_range(63)),
                          6'($urandom_range(63)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty field reads, including the spare action code.
        send_item(lage_pkg::ACT_READ, 6'd0, 6'd0);
        send_item(ACT_SPARE, 6'd63, 6'd63);
        // Blinker across the last and first index of the field.
        send_item(lage_pkg::ACT_SET, 6'd63, 6'd63);
        send_item(lage_pkg::ACT_SET, 6'd0, 6'd0);
        send_item(lage_pkg::ACT_SET, 6'd1, 6'd0);
        send_item(ACT_SPARE, 6'd63, 6'd63);
        send_item(lage_pkg::ACT_ADVANCE, 6'd0, 6'd1);
        send_item(lage_pkg::ACT_ADVANCE, 6'd0, 6'd63);
        // Blinker running over a column edge into the next row.
        send_item(lage_pkg::ACT_SET, 6'd62, 6'd10);
        send_item(lage_pkg::ACT_SET, 6'd63, 6'd10);
        send_item(lage_pkg::ACT_SET, 6'd0, 6'd11);
        send_item(lage_pkg::ACT_ADVANCE, 6'd63, 6'd9);
        send_item(lage_pkg::ACT_ADVANCE, 6'd62, 6'd10);
        // Opposite corners, then a still block.
        send_item(lage_pkg::ACT_SET, 6'd63, 6'd0);
        send_item(lage_pkg::ACT_SET, 6'd0, 6'd63);
        send_item(lage_pkg::ACT_SET, 6'd20, 6'd20);
        send_item(lage_pkg::ACT_SET, 6'd21, 6'd20);
        send_item(lage_pkg::ACT_SET, 6'd20, 6'd21);
        send_item(lage_pkg::ACT_SET, 6'd21, 6'd21);
        send_item(lage_pkg::ACT_ADVANCE, 6'd20, 6'd20);
        send_item(lage_pkg::ACT_READ, 6'd63, 6'd0);
        send_item(lage_pkg::ACT_ADVANCE, 6'd22, 6'd22);

        run_random_until(ITEM_TARGET / 3);
        sender_idle_pct   = 70;
        receiver_idle_pct = 38;
        run_random_until(2 * ITEM_TARGET / 3);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_until(ITEM_TARGET);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_life_automaton_generation_engine: done, clean");
        else
            $display("tb_life_automaton_generation_engine: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_life_automaton_generation_engine: done, errors");
        $finish;
    end

endmodule
